@@ rtl/rtch_pkg.sv @@
package rtch_pkg;

   // field and datapath widths
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int CROSS_W   = 2 * DIFF_W + 1;
   localparam int LO_W      = CROSS_W - DIFF_W;
   localparam int MUL_A_W   = LO_W + 1;
   localparam int PROD_W    = MUL_A_W + DIFF_W;
   localparam int ACC_W     = 104;
   localparam int T_W       = 31;
   localparam int DIV_W     = ACC_W + T_W + 1;
   localparam int DIV_CNT_W = 5;
   localparam int MODEL_W   = 8;
   localparam int TRI_OUT_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_CSR   = 6;

   localparam int FRAC_BITS_DEF      = 16;
   localparam int TRI_INDEX_BITS_DEF = 16;

   localparam logic [T_W-1:0] T_SAT = '1;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAY_START_X = 3'd0,
      CSR_RAY_START_Y = 3'd1,
      CSR_RAY_START_Z = 3'd2,
      CSR_RAY_END_X   = 3'd3,
      CSR_RAY_END_Y   = 3'd4,
      CSR_RAY_END_Z   = 3'd5
   } csr_index_type;

   // sequencer states
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CROSS  = 8'b0000_0010,
      S_DOT    = 8'b0000_0100,
      S_WAIT   = 8'b0000_1000,
      S_CHECK  = 8'b0001_0000,
      S_BOUNDS = 8'b0010_0000,
      S_DIV    = 8'b0100_0000,
      S_UPDATE = 8'b1000_0000
   } state_type;

   // accumulator control, travels with the product
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_LOAD = 2'd1,
      OP_ADD  = 2'd2,
      OP_SUB  = 2'd3
   } acc_op_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'd0,
      DST_CX0  = 3'd1,
      DST_CX1  = 3'd2,
      DST_CX2  = 3'd3,
      DST_DET  = 3'd4,
      DST_TN   = 3'd5,
      DST_UN   = 3'd6,
      DST_VN   = 3'd7
   } acc_dst_type;

   typedef struct packed {
      acc_op_type  op;
      logic        shift;
      acc_dst_type dst;
   } acc_ctrl_type;

endpackage

@@ rtl/rtch_req_if.sv @@
interface rtch_req_if import rtch_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [MODEL_W-1:0]        model_id;
   logic signed [COORD_W-1:0] vertex_a_x;
   logic signed [COORD_W-1:0] vertex_a_y;
   logic signed [COORD_W-1:0] vertex_a_z;
   logic signed [COORD_W-1:0] vertex_b_x;
   logic signed [COORD_W-1:0] vertex_b_y;
   logic signed [COORD_W-1:0] vertex_b_z;
   logic signed [COORD_W-1:0] vertex_c_x;
   logic signed [COORD_W-1:0] vertex_c_y;
   logic signed [COORD_W-1:0] vertex_c_z;
   logic                      last_triangle;

   modport source (
      output valid, model_id, vertex_a_x, vertex_a_y, vertex_a_z,
      output vertex_b_x, vertex_b_y, vertex_b_z,
      output vertex_c_x, vertex_c_y, vertex_c_z, last_triangle,
      input  ready
   );

   modport sink (
      input  valid, model_id, vertex_a_x, vertex_a_y, vertex_a_z,
      input  vertex_b_x, vertex_b_y, vertex_b_z,
      input  vertex_c_x, vertex_c_y, vertex_c_z, last_triangle,
      output ready
   );
endinterface

@@ rtl/rtch_rsp_if.sv @@
interface rtch_rsp_if import rtch_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [T_W-1:0]       nearest_t;
   logic [MODEL_W-1:0]   nearest_model;
   logic [TRI_OUT_W-1:0] nearest_triangle;

   modport source (
      output valid, hit, nearest_t, nearest_model, nearest_triangle,
      input  ready
   );

   modport sink (
      input  valid, hit, nearest_t, nearest_model, nearest_triangle,
      output ready
   );
endinterface

@@ rtl/ray_triangle_closest_hit_core.sv @@
// channel   | dir | handshake     | payload
// ----------+-----+---------------+---------------------------------------------
// req_bus   | in  | valid / ready | model_id, vertex_{a,b,c}_{x,y,z}, last_triangle
// rsp_bus   | out | valid / ready | hit, nearest_t, nearest_model, nearest_triangle
// csr_*     | in  | csr_we        | csr_index, csr_wdata (ray start and end)
//
// a hit goes through a capture, 42 passes through the one shared 35x33
// multiplier (18 for three cross products, 24 for four dot products in two halves),
// a drain, the sign and bounds checks, 32 restoring divide steps and an update; a
// saturated t ends the divide after one step, and a miss skips the divide.
// reset is synchronous and clears all control state and the closest-hit record.
// a request is taken only in idle; a held result stalls the update of a last triangle
module ray_triangle_closest_hit_core import rtch_pkg::*; #(
   parameter int FRAC_BITS      = FRAC_BITS_DEF,
   parameter int TRI_INDEX_BITS = TRI_INDEX_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   rtch_req_if.sink             req_bus,
   rtch_rsp_if.source           rsp_bus
);

   // ray registers
   logic signed [COORD_W-1:0] cfg_ff [NUM_CSR];

   // control state
   state_type                 state_ff, state_in;
   logic [1:0]                pass_ff, pass_in;
   logic [2:0]                step_ff, step_in;
   logic                      dotsel_ff, dotsel_in;
   logic [DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                      hit_ff, hit_in;
   acc_ctrl_type              ctrl_ff, ctrl_in;

   // closest-hit record and counters
   logic                      best_valid_ff, best_valid_in;
   logic [T_W-1:0]            best_t_ff, best_t_in;
   logic [MODEL_W-1:0]        best_model_ff, best_model_in;
   logic [TRI_INDEX_BITS-1:0] best_tri_ff, best_tri_in;
   logic [TRI_INDEX_BITS-1:0] tri_cnt_ff, tri_cnt_in;
   logic [MODEL_W-1:0]        prev_model_ff, prev_model_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic [T_W-1:0]            rsp_t_ff, rsp_t_in;
   logic [MODEL_W-1:0]        rsp_model_ff, rsp_model_in;
   logic [TRI_OUT_W-1:0]      rsp_tri_ff, rsp_tri_in;

   // item payload
   logic [MODEL_W-1:0]        model_ff, model_in;
   logic [TRI_INDEX_BITS-1:0] ord_ff, ord_in;
   logic                      last_ff, last_in;
   logic signed [DIFF_W-1:0]  d_ff [3];
   logic signed [DIFF_W-1:0]  d_in [3];
   logic signed [DIFF_W-1:0]  r_ff [3];
   logic signed [DIFF_W-1:0]  r_in [3];
   logic signed [DIFF_W-1:0]  e1_ff [3];
   logic signed [DIFF_W-1:0]  e1_in [3];
   logic signed [DIFF_W-1:0]  e2_ff [3];
   logic signed [DIFF_W-1:0]  e2_in [3];
   logic signed [CROSS_W-1:0] cx_ff [3];
   logic signed [CROSS_W-1:0] cx_in [3];
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   det_ff, det_in;
   logic signed [ACC_W-1:0]   tn_ff, tn_in;
   logic signed [ACC_W-1:0]   un_ff, un_in;
   logic signed [ACC_W-1:0]   vn_ff, vn_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIV_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]          den_ff, den_in;
   logic [T_W-1:0]            q_ff, q_in;

   // combinational helpers
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [DIFF_W-1:0]  mul_b;
   logic signed [DIFF_W-1:0]  xv [3];
   logic signed [DIFF_W-1:0]  yv [3];
   logic [1:0]                xi, yi, kk;
   logic signed [ACC_W-1:0]   prod_sh;
   logic                      accept;
   logic                      ge;
   logic                      miss;
   logic                      take;
   logic                      nb_valid;
   logic [T_W-1:0]            nb_t;
   logic [MODEL_W-1:0]        nb_model;
   logic [TRI_INDEX_BITS-1:0] nb_tri;
   logic [TRI_INDEX_BITS-1:0] ord_new;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.hit              = rsp_hit_ff;
   assign rsp_bus.nearest_t        = rsp_t_ff;
   assign rsp_bus.nearest_model    = rsp_model_ff;
   assign rsp_bus.nearest_triangle = rsp_tri_ff;

   // ray register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAY_START_X: cfg_ff[0] <= csr_wdata;
            CSR_RAY_START_Y: cfg_ff[1] <= csr_wdata;
            CSR_RAY_START_Z: cfg_ff[2] <= csr_wdata;
            CSR_RAY_END_X:   cfg_ff[3] <= csr_wdata;
            CSR_RAY_END_Y:   cfg_ff[4] <= csr_wdata;
            CSR_RAY_END_Z:   cfg_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // cross product operand vectors per pass
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (pass_ff)
            2'd1: begin
               xv[i] = r_ff[i];
               yv[i] = e2_ff[i];
            end
            2'd2: begin
               xv[i] = e1_ff[i];
               yv[i] = r_ff[i];
            end
            default: begin
               xv[i] = e1_ff[i];
               yv[i] = e2_ff[i];
            end
         endcase
      end
      case (step_ff)
         3'd0: begin xi = 2'd1; yi = 2'd2; end
         3'd1: begin xi = 2'd2; yi = 2'd1; end
         3'd2: begin xi = 2'd2; yi = 2'd0; end
         3'd3: begin xi = 2'd0; yi = 2'd2; end
         3'd4: begin xi = 2'd0; yi = 2'd1; end
         3'd5: begin xi = 2'd1; yi = 2'd0; end
         default: begin xi = 2'd0; yi = 2'd0; end
      endcase
      kk = step_ff[2:1];
   end

   // shared multiplier issue
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      ctrl_in = '{op: OP_NONE, shift: 1'b0, dst: DST_NONE};
      if (state_ff == S_CROSS) begin
         mul_a        = MUL_A_W'(xv[xi]);
         mul_b        = yv[yi];
         ctrl_in.op   = step_ff[0] ? OP_SUB : OP_LOAD;
         if (step_ff[0]) begin
            case (kk)
               2'd0:    ctrl_in.dst = DST_CX0;
               2'd1:    ctrl_in.dst = DST_CX1;
               default: ctrl_in.dst = DST_CX2;
            endcase
         end
      end else if (state_ff == S_DOT) begin
         // low half unsigned, high half signed and shifted up
         if (step_ff[0]) begin
            mul_a = MUL_A_W'($signed(cx_ff[kk][CROSS_W-1:LO_W]));
         end else begin
            mul_a = {1'b0, cx_ff[kk][LO_W-1:0]};
         end
         mul_b         = dotsel_ff ? r_ff[kk] : d_ff[kk];
         ctrl_in.op    = (step_ff == 3'd0) ? OP_LOAD : OP_ADD;
         ctrl_in.shift = step_ff[0];
         if (step_ff == 3'd5) begin
            case (pass_ff)
               2'd0:    ctrl_in.dst = dotsel_ff ? DST_TN : DST_DET;
               2'd1:    ctrl_in.dst = DST_UN;
               default: ctrl_in.dst = DST_VN;
            endcase
         end
      end
      prod_in = mul_a * mul_b;
   end

   // accumulate stage
   always_comb begin
      prod_sh = ACC_W'(prod_ff);
      if (ctrl_ff.shift) begin
         prod_sh = prod_sh <<< LO_W;
      end
      case (ctrl_ff.op)
         OP_LOAD: acc_in = prod_sh;
         OP_ADD:  acc_in = acc_ff + prod_sh;
         OP_SUB:  acc_in = acc_ff - prod_sh;
         default: acc_in = acc_ff;
      endcase
   end

   // divider compare
   assign ge = (rem_ff >= den_ff);

   // bounds test on normalized numerators
   assign miss = tn_ff[ACC_W-1] || un_ff[ACC_W-1] || vn_ff[ACC_W-1] ||
                 (un_ff > det_ff) || (vn_ff > det_ff) || ((un_ff + vn_ff) > det_ff);

   // closest-hit candidate
   assign take     = hit_ff && (!best_valid_ff || (q_ff < best_t_ff));
   assign nb_valid = best_valid_ff || take;
   assign nb_t     = take ? q_ff : best_t_ff;
   assign nb_model = take ? model_ff : best_model_ff;
   assign nb_tri   = take ? ord_ff : best_tri_ff;

   // triangle ordinal within model
   assign ord_new = (req_bus.model_id == prev_model_ff) ? tri_cnt_ff : '0;

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      step_in       = step_ff;
      dotsel_in     = dotsel_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      best_valid_in = best_valid_ff;
      best_t_in     = best_t_ff;
      best_model_in = best_model_ff;
      best_tri_in   = best_tri_ff;
      tri_cnt_in    = tri_cnt_ff;
      prev_model_in = prev_model_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_t_in      = rsp_t_ff;
      rsp_model_in  = rsp_model_ff;
      rsp_tri_in    = rsp_tri_ff;
      model_in      = model_ff;
      ord_in        = ord_ff;
      last_in       = last_ff;
      d_in          = d_ff;
      r_in          = r_ff;
      e1_in         = e1_ff;
      e2_in         = e2_ff;
      cx_in         = cx_ff;
      det_in        = det_ff;
      tn_in         = tn_ff;
      un_in         = un_ff;
      vn_in         = vn_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      q_in          = q_ff;

      // results leaving the accumulator
      case (ctrl_ff.dst)
         DST_CX0: cx_in[0] = acc_in[CROSS_W-1:0];
         DST_CX1: cx_in[1] = acc_in[CROSS_W-1:0];
         DST_CX2: cx_in[2] = acc_in[CROSS_W-1:0];
         DST_DET: det_in   = acc_in;
         DST_TN:  tn_in    = acc_in;
         DST_UN:  un_in    = acc_in;
         DST_VN:  vn_in    = acc_in;
         default: ;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               model_in      = req_bus.model_id;
               last_in       = req_bus.last_triangle;
               ord_in        = ord_new;
               tri_cnt_in    = ord_new + 1'b1;
               prev_model_in = req_bus.model_id;
               d_in[0]  = DIFF_W'(cfg_ff[0]) - DIFF_W'(cfg_ff[3]);
               d_in[1]  = DIFF_W'(cfg_ff[1]) - DIFF_W'(cfg_ff[4]);
               d_in[2]  = DIFF_W'(cfg_ff[2]) - DIFF_W'(cfg_ff[5]);
               r_in[0]  = DIFF_W'(cfg_ff[0]) - DIFF_W'(req_bus.vertex_a_x);
               r_in[1]  = DIFF_W'(cfg_ff[1]) - DIFF_W'(req_bus.vertex_a_y);
               r_in[2]  = DIFF_W'(cfg_ff[2]) - DIFF_W'(req_bus.vertex_a_z);
               e1_in[0] = DIFF_W'(req_bus.vertex_b_x) - DIFF_W'(req_bus.vertex_a_x);
               e1_in[1] = DIFF_W'(req_bus.vertex_b_y) - DIFF_W'(req_bus.vertex_a_y);
               e1_in[2] = DIFF_W'(req_bus.vertex_b_z) - DIFF_W'(req_bus.vertex_a_z);
               e2_in[0] = DIFF_W'(req_bus.vertex_c_x) - DIFF_W'(req_bus.vertex_a_x);
               e2_in[1] = DIFF_W'(req_bus.vertex_c_y) - DIFF_W'(req_bus.vertex_a_y);
               e2_in[2] = DIFF_W'(req_bus.vertex_c_z) - DIFF_W'(req_bus.vertex_a_z);
               pass_in   = 2'd0;
               step_in   = 3'd0;
               dotsel_in = 1'b0;
               state_in  = S_CROSS;
            end
         end
         S_CROSS: begin
            if (step_ff == 3'd5) begin
               step_in  = 3'd0;
               state_in = S_DOT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_DOT: begin
            if (step_ff == 3'd5) begin
               step_in = 3'd0;
               if (pass_ff == 2'd0 && !dotsel_ff) begin
                  dotsel_in = 1'b1;
               end else begin
                  dotsel_in = 1'b0;
                  if (pass_ff == 2'd2) begin
                     state_in = S_WAIT;
                  end else begin
                     pass_in  = pass_ff + 2'd1;
                     state_in = S_CROSS;
                  end
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_WAIT: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // singular system misses, negative determinant flips all signs
            if (det_ff == '0) begin
               hit_in   = 1'b0;
               state_in = S_UPDATE;
            end else begin
               if (det_ff[ACC_W-1]) begin
                  det_in = -det_ff;
                  tn_in  = -tn_ff;
                  un_in  = -un_ff;
                  vn_in  = -vn_ff;
               end
               state_in = S_BOUNDS;
            end
         end
         S_BOUNDS: begin
            if (miss) begin
               hit_in   = 1'b0;
               state_in = S_UPDATE;
            end else begin
               rem_in   = DIV_W'(tn_ff) << FRAC_BITS;
               den_in   = DIV_W'(det_ff) << T_W;
               q_in     = '0;
               cnt_in   = DIV_CNT_W'(T_W);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one restoring step per cycle, first step is the saturation test
            if (ge) begin
               rem_in = rem_ff - den_ff;
            end
            den_in = den_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(T_W)) begin
               if (ge) begin
                  q_in     = T_SAT;
                  hit_in   = 1'b1;
                  state_in = S_UPDATE;
               end
            end else begin
               q_in = {q_ff[T_W-2:0], ge};
               if (cnt_ff == '0) begin
                  hit_in   = 1'b1;
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            if (last_ff) begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_in  = 1'b1;
                  rsp_hit_in    = nb_valid;
                  rsp_t_in      = nb_t;
                  rsp_model_in  = nb_model;
                  rsp_tri_in    = TRI_OUT_W'(nb_tri);
                  best_valid_in = 1'b0;
                  best_t_in     = '0;
                  best_model_in = '0;
                  best_tri_in   = '0;
                  tri_cnt_in    = '0;
                  prev_model_in = '0;
                  state_in      = S_IDLE;
               end
            end else begin
               best_valid_in = nb_valid;
               best_t_in     = nb_t;
               best_model_in = nb_model;
               best_tri_in   = nb_tri;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pass_ff       <= '0;
         step_ff       <= '0;
         dotsel_ff     <= 1'b0;
         cnt_ff        <= '0;
         hit_ff        <= 1'b0;
         ctrl_ff       <= '{op: OP_NONE, shift: 1'b0, dst: DST_NONE};
         best_valid_ff <= 1'b0;
         best_t_ff     <= '0;
         best_model_ff <= '0;
         best_tri_ff   <= '0;
         tri_cnt_ff    <= '0;
         prev_model_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         step_ff       <= step_in;
         dotsel_ff     <= dotsel_in;
         cnt_ff        <= cnt_in;
         hit_ff        <= hit_in;
         ctrl_ff       <= ctrl_in;
         best_valid_ff <= best_valid_in;
         best_t_ff     <= best_t_in;
         best_model_ff <= best_model_in;
         best_tri_ff   <= best_tri_in;
         tri_cnt_ff    <= tri_cnt_in;
         prev_model_ff <= prev_model_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_t_ff     <= rsp_t_in;
      rsp_model_ff <= rsp_model_in;
      rsp_tri_ff   <= rsp_tri_in;
      model_ff     <= model_in;
      ord_ff       <= ord_in;
      last_ff      <= last_in;
      d_ff         <= d_in;
      r_ff         <= r_in;
      e1_ff        <= e1_in;
      e2_ff        <= e2_in;
      cx_ff        <= cx_in;
      acc_ff       <= acc_in;
      det_ff       <= det_in;
      tn_ff        <= tn_in;
      un_ff        <= un_in;
      vn_ff        <= vn_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      q_ff         <= q_in;
   end

endmodule

@@ tb/tb_ray_triangle_closest_hit_core.sv @@
`timescale 1ns / 1ps

module tb_ray_triangle_closest_hit_core;
   import rtch_pkg::*;

   typedef logic signed [127:0] wide_type;
   typedef struct packed {
      wide_type x;
      wide_type y;
      wide_type z;
   } vec_type;

   typedef struct packed {
      logic [MODEL_W-1:0]        model;
      logic signed [COORD_W-1:0] ax, ay, az;
      logic signed [COORD_W-1:0] bx, by, bz;
      logic signed [COORD_W-1:0] cx, cy, cz;
      logic                      last;
   } triangle_type;

   typedef struct packed {
      logic                 hit;
      logic [T_W-1:0]       t;
      logic [MODEL_W-1:0]   model;
      logic [TRI_OUT_W-1:0] index;
   } nearest_hit_type;

   typedef struct {
      triangle_type    tri_item;
      bit              typed;
      nearest_hit_type result;
   } table_row_type;

   localparam int UNIT       = 65536;
   localparam int ITEM_COUNT = 1950;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_wdata = '0;

   rtch_req_if req_bus ();
   rtch_rsp_if rsp_bus ();

   ray_triangle_closest_hit_core uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always #5 clock = ~clock;

   // ray setting and closest-hit state mirrored from the block
   logic signed [COORD_W-1:0] ray_cfg [NUM_CSR];
   logic                      best_valid;
   logic [T_W-1:0]            best_t;
   logic [MODEL_W-1:0]        best_model;
   logic [15:0]               best_index;
   logic [15:0]               tri_counter;
   logic [MODEL_W-1:0]        prev_model;

   nearest_hit_type expected_hits [$];
   table_row_type   directed_rows [$];

   int errors = 0;
   int sent = 0;
   int checked = 0;
   int hits_seen = 0;
   int ray_settings = 0;
   int burst_left = 0;

   // vector helpers on exact wide integers
   function automatic vec_type mkvec(logic signed [31:0] x, logic signed [31:0] y,
                                     logic signed [31:0] z);
      vec_type v;
      v.x = wide_type'(x);
      v.y = wide_type'(y);
      v.z = wide_type'(z);
      return v;
   endfunction

   function automatic vec_type vsub(vec_type a, vec_type b);
      vec_type v;
      v.x = a.x - b.x;
      v.y = a.y - b.y;
      v.z = a.z - b.z;
      return v;
   endfunction

   function automatic vec_type vcross(vec_type a, vec_type b);
      vec_type v;
      v.x = a.y * b.z - a.z * b.y;
      v.y = a.z * b.x - a.x * b.z;
      v.z = a.x * b.y - a.y * b.x;
      return v;
   endfunction

   function automatic wide_type vdot(vec_type a, vec_type b);
      wide_type s;
      s = a.x * b.x + a.y * b.y + a.z * b.z;
      return s;
   endfunction

   // solve for t, u, v by cramer's rule; returns 1 on a hit
   function automatic bit ray_hits(triangle_type tr, output logic [T_W-1:0] t_q);
      vec_type  p0, p1, a, b, c, d, e1, e2, r, cx;
      wide_type det, tn, un, vn, num;
      logic [127:0] quo;
      p0 = mkvec(ray_cfg[0], ray_cfg[1], ray_cfg[2]);
      p1 = mkvec(ray_cfg[3], ray_cfg[4], ray_cfg[5]);
      a = mkvec(tr.ax, tr.ay, tr.az);
      b = mkvec(tr.bx, tr.by, tr.bz);
      c = mkvec(tr.cx, tr.cy, tr.cz);
      d = vsub(p0, p1);
      e1 = vsub(b, a);
      e2 = vsub(c, a);
      r = vsub(p0, a);
      cx = vcross(e1, e2);
      det = vdot(d, cx);
      tn = vdot(r, cx);
      cx = vcross(r, e2);
      un = vdot(d, cx);
      cx = vcross(e1, r);
      vn = vdot(d, cx);
      t_q = '0;
      if (det == 0) return 1'b0;
      if (det < 0) begin
         det = -det;
         tn = -tn;
         un = -un;
         vn = -vn;
      end
      if (tn < 0 || un < 0 || vn < 0) return 1'b0;
      if (un > det || vn > det || un + vn > det) return 1'b0;
      num = tn <<< FRAC_BITS_DEF;
      quo = $unsigned(num) / $unsigned(det);
      t_q = (quo > 128'(T_SAT)) ? T_SAT : quo[T_W-1:0];
      return 1'b1;
   endfunction

   // closest-hit tracking for one accepted triangle
   function automatic void closest_hit_step(triangle_type tr, output bit emit,
                                            output nearest_hit_type res);
      logic [15:0]    ordinal;
      logic [T_W-1:0] t_q;
      ordinal = (tr.model == prev_model) ? tri_counter : 16'd0;
      tri_counter = ordinal + 16'd1;
      prev_model = tr.model;
      if (ray_hits(tr, t_q) && (!best_valid || t_q < best_t)) begin
         best_valid = 1'b1;
         best_t = t_q;
         best_model = tr.model;
         best_index = ordinal;
      end
      emit = tr.last;
      res = '0;
      if (tr.last) begin
         if (best_valid) res = '{1'b1, best_t, best_model, best_index};
         best_valid = 1'b0;
         best_t = '0;
         best_model = '0;
         best_index = '0;
         tri_counter = '0;
         prev_model = '0;
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      nearest_hit_type exp_hit;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_hits.size() == 0) begin
            report_mismatch("unexpected result, hit", rsp_bus.hit, 0);
         end else begin
            exp_hit = expected_hits.pop_front();
            checked++;
            if (rsp_bus.hit) hits_seen++;
            if (rsp_bus.hit !== exp_hit.hit)
               report_mismatch("hit", rsp_bus.hit, exp_hit.hit);
            if (rsp_bus.nearest_t !== exp_hit.t)
               report_mismatch("nearest_t", rsp_bus.nearest_t, exp_hit.t);
            if (rsp_bus.nearest_model !== exp_hit.model)
               report_mismatch("nearest_model", rsp_bus.nearest_model, exp_hit.model);
            if (rsp_bus.nearest_triangle !== exp_hit.index)
               report_mismatch("nearest_triangle", rsp_bus.nearest_triangle,
                               exp_hit.index);
         end
      end
   end

   // receiver stall pattern, in randomly chosen modes
   int rx_mode = 0;
   int rx_cycles = 0;
   int rx_stall = 0;
   always @(negedge clock) begin
      if (rx_cycles == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_cycles = $urandom_range(50, 400);
      end
      rx_cycles--;
      case (rx_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: begin
            if (rx_stall > 0) rx_stall--;
            else if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(10, 120);
            rsp_bus.ready <= (rx_stall == 0);
         end
         default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // write all six ray registers, one per cycle
   task automatic set_ray(logic signed [31:0] sx, logic signed [31:0] sy,
                          logic signed [31:0] sz, logic signed [31:0] ex,
                          logic signed [31:0] ey, logic signed [31:0] ez);
      logic signed [31:0] vals [NUM_CSR];
      vals = '{sx, sy, sz, ex, ey, ez};
      for (int i = 0; i < NUM_CSR; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         ray_cfg[i] = vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      ray_settings++;
   endtask

   // drop valid and hold off until every result is back and the core is idle
   task automatic drain_requests();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_request(triangle_type tr, bit typed, nearest_hit_type typed_res);
      bit              emit;
      nearest_hit_type res;
      @(negedge clock);
      req_bus.model_id <= tr.model;
      req_bus.vertex_a_x <= tr.ax;
      req_bus.vertex_a_y <= tr.ay;
      req_bus.vertex_a_z <= tr.az;
      req_bus.vertex_b_x <= tr.bx;
      req_bus.vertex_b_y <= tr.by;
      req_bus.vertex_b_z <= tr.bz;
      req_bus.vertex_c_x <= tr.cx;
      req_bus.vertex_c_y <= tr.cy;
      req_bus.vertex_c_z <= tr.cz;
      req_bus.last_triangle <= tr.last;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      closest_hit_step(tr, emit, res);
      if (typed) res = typed_res;
      if (emit) expected_hits = {expected_hits, res};
      sent++;
      // bursts of back-to-back requests with random gaps
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 20);
      end
   endtask

   // triangle in whole units, for the directed table
   function automatic triangle_type unit_tri(int m, int ax, int ay, int az, int bx,
                                             int by, int bz, int cx, int cy, int cz,
                                             bit last);
      return '{m[7:0], ax * UNIT, ay * UNIT, az * UNIT, bx * UNIT, by * UNIT, bz * UNIT,
               cx * UNIT, cy * UNIT, cz * UNIT, last};
   endfunction

   function automatic void add_row(triangle_type tr, bit typed, nearest_hit_type res);
      table_row_type row;
      row.tri_item = tr;
      row.typed = typed;
      row.result = res;
      directed_rows = {directed_rows, row};
   endfunction

   // triangle whose vertices scatter around a point on or near the ray
   function automatic triangle_type aimed_tri(logic [7:0] m, bit last);
      longint    q [3];
      int        tq, span;
      logic [31:0] vtx [9];
      tq = int'($urandom_range(0, 420)) - 60;
      for (int k = 0; k < 3; k++)
         q[k] = longint'(ray_cfg[k]) +
                (((longint'(ray_cfg[k + 3]) - longint'(ray_cfg[k])) * tq) >>> 8);
      span = 1 << $urandom_range(2, 24);
      for (int k = 0; k < 9; k++)
         vtx[k] = 32'(q[k % 3] + longint'($urandom_range(0, 2 * span)) - span);
      return '{m, vtx[0], vtx[1], vtx[2], vtx[3], vtx[4], vtx[5], vtx[6], vtx[7],
               vtx[8], last};
   endfunction

   function automatic triangle_type noise_tri(logic [7:0] m, bit last);
      return '{m, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, last};
   endfunction

   // new ray for a phase of the random part
   task automatic pick_ray(int kind);
      int s [3];
      for (int k = 0; k < 3; k++) s[k] = int'($urandom_range(0, 128 * UNIT)) - 64 * UNIT;
      case (kind)
         0: set_ray(s[0], s[1], s[2], int'($urandom_range(0, 128 * UNIT)) - 64 * UNIT,
                    int'($urandom_range(0, 128 * UNIT)) - 64 * UNIT,
                    int'($urandom_range(0, 128 * UNIT)) - 64 * UNIT);
         // very short ray: t easily saturates
         1: set_ray(s[0], s[1], s[2], s[0] + int'($urandom_range(1, 3)), s[1],
                    s[2] - int'($urandom_range(0, 2)));
         2: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         3: set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
         4: set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
         default: set_ray(0, 0, 0, 0, 0, 0);
      endcase
   endtask

   // timeout
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      nearest_hit_type miss, dummy;
      logic [7:0]      set_model;
      int              set_len, kind, phase_items;
      bit              aimed;

      req_bus.valid = 1'b0;
      req_bus.model_id = '0;
      req_bus.vertex_a_x = '0;
      req_bus.vertex_a_y = '0;
      req_bus.vertex_a_z = '0;
      req_bus.vertex_b_x = '0;
      req_bus.vertex_b_y = '0;
      req_bus.vertex_b_z = '0;
      req_bus.vertex_c_x = '0;
      req_bus.vertex_c_y = '0;
      req_bus.vertex_c_z = '0;
      req_bus.last_triangle = 1'b0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < NUM_CSR; i++) ray_cfg[i] = '0;
      best_valid = 1'b0;
      best_t = '0;
      best_model = '0;
      best_index = '0;
      tri_counter = '0;
      prev_model = '0;
      miss = '0;
      dummy = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset the ray is a single point: every system is singular
      send_request(unit_tri(0, 5, -1, -1, 5, 3, -1, 5, -1, 3, 1), 1'b1, miss);
      drain_requests();

      // directed table, ray from the origin to x=10, planes at x=5 give t=0.5
      add_row(unit_tri(3, 5, -1, -1, 5, 3, -1, 5, -1, 3, 1), 1'b1,
              '{1'b1, 31'h8000, 8'd3, 16'd0});
      // behind the start
      add_row(unit_tri(3, -5, -1, -1, -5, 3, -1, -5, -1, 3, 1), 1'b1, miss);
      // collinear vertices
      add_row(unit_tri(3, 1, 1, 1, 2, 2, 2, 3, 3, 3, 1), 1'b1, miss);
      add_row('{8'hFF, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1} , 1'b1,
              miss);
      add_row('{8'h00, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 1'b1}, 1'b1, miss);
      // nearer hit in the middle of a set
      add_row(unit_tri(7, 8, -1, -1, 8, 3, -1, 8, -1, 3, 0), 1'b0, dummy);
      add_row(unit_tri(7, 5, -1, -1, 5, 3, -1, 5, -1, 3, 0), 1'b0, dummy);
      add_row(unit_tri(7, 9, -1, -1, 9, 3, -1, 9, -1, 3, 1), 1'b1,
              '{1'b1, 31'h8000, 8'd7, 16'd1});
      // equal t: the first one stays
      add_row(unit_tri(1, 5, -1, -1, 5, 3, -1, 5, -1, 3, 0), 1'b0, dummy);
      add_row(unit_tri(2, 5, -1, -1, 5, 3, -1, 5, -1, 3, 1), 1'b1,
              '{1'b1, 31'h8000, 8'd1, 16'd0});
      // hit beyond the end point
      add_row(unit_tri(9, 20, -1, -1, 20, 3, -1, 20, -1, 3, 1), 1'b0, dummy);
      // ray through a vertex
      add_row(unit_tri(4, 5, 0, 0, 5, 4, 0, 5, 0, 4, 1), 1'b1,
              '{1'b1, 31'h8000, 8'd4, 16'd0});
      // ray on the edge opposite the first vertex
      add_row(unit_tri(4, 5, -2, -2, 5, 2, -2, 5, -2, 2, 1), 1'b0, dummy);
      // just outside the triangle
      add_row(unit_tri(4, 5, 1, 1, 5, 3, 1, 5, 1, 3, 1), 1'b1, miss);
      // model change restarts the ordinal
      add_row(unit_tri(5, 9, -1, -1, 9, 3, -1, 9, -1, 3, 0), 1'b0, dummy);
      add_row(unit_tri(5, 9, -1, -1, 9, 3, -1, 9, -1, 3, 0), 1'b0, dummy);
      add_row(unit_tri(6, 9, -1, -1, 9, 3, -1, 9, -1, 3, 0), 1'b0, dummy);
      add_row(unit_tri(5, 5, -1, -1, 5, 3, -1, 5, -1, 3, 1), 1'b1,
              '{1'b1, 31'h8000, 8'd5, 16'd0});
      // back-facing winding
      add_row(unit_tri(8, 5, -1, -1, 5, -1, 3, 5, 3, -1, 1), 1'b0, dummy);

      set_ray(0, 0, 0, 10 * UNIT, 0, 0);
      foreach (directed_rows[i])
         send_request(directed_rows[i].tri_item, directed_rows[i].typed,
                      directed_rows[i].result);
      drain_requests();

      // random part: phases of ray settings, sets of aimed triangles plus noise
      kind = 0;
      while (sent < ITEM_COUNT) begin
         pick_ray(kind);
         kind = (kind + 1) % 6;
         phase_items = 0;
         while (phase_items < 150 && sent < ITEM_COUNT) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(1, 6);
            set_model = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            for (int i = 0; i < set_len; i++) begin
               triangle_type tr;
               bit           last_one;
               last_one = (i == set_len - 1);
               if ($urandom_range(0, 5) == 0) set_model = 8'($urandom);
               aimed = ($urandom_range(0, 4) != 0);
               tr = aimed ? aimed_tri(set_model, last_one) : noise_tri(set_model, last_one);
               send_request(tr, 1'b0, dummy);
               // occasional repeat of the same triangle for equal t
               if (!last_one && $urandom_range(0, 15) == 0) begin
                  send_request(tr, 1'b0, dummy);
                  phase_items++;
               end
               phase_items++;
            end
            if ($urandom_range(0, 30) == 0) drain_requests();
         end
         drain_requests();
      end

      while (expected_hits.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("Summary: %0d triangles over %0d ray settings, %0d results checked (%0d hits)",
               sent, ray_settings, checked, hits_seen);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ ray_triangle_closest_hit_core.f @@
rtl/rtch_pkg.sv
rtl/rtch_req_if.sv
rtl/rtch_rsp_if.sv
rtl/ray_triangle_closest_hit_core.sv
tb/tb_ray_triangle_closest_hit_core.sv
